// ===== rtl/tunm_pkg.sv =====
package tunm_pkg;

    // Default needle capacity in bytes
    localparam int DEF_MAX_NEEDLE = 32;

    // Request actions
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_CHAR   = 2'd2;
    localparam logic [1:0] ACT_END    = 2'd3;

    // Match tiers
    localparam logic [2:0] TIER_NONE      = 3'd0;
    localparam logic [2:0] TIER_PREFIX    = 3'd1;
    localparam logic [2:0] TIER_SEGMENT   = 3'd2;
    localparam logic [2:0] TIER_SUBSTRING = 3'd3;
    localparam logic [2:0] TIER_SCATTERED = 3'd4;

    // Configuration register indexes
    localparam logic REG_SCATTERED_MIN = 1'b0;
    localparam logic REG_SPAN_FACTOR   = 1'b1;

    localparam logic [5:0] SML_RESET  = 6'd3;
    localparam logic [2:0] SPAN_RESET = 3'd2;

    // Characters of interest
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_QUERY  = 8'h3F;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // Window age that marks "no window"
    localparam logic [7:0] AGE_NONE = 8'hFF;

    typedef struct packed {
        logic restart;  // start a fresh target scan
        logic step;     // consume one target character
    } scan_ctrl_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return c inside {CH_SLASH, CH_DOT, CH_DASH, CH_UNDER, CH_PLUS, CH_COLON, CH_TILDE};
    endfunction

    function automatic logic [7:0] age_next(input logic [7:0] a);
        return (a >= AGE_NONE - 8'd1) ? AGE_NONE : a + 8'd1;
    endfunction

endpackage

// ===== rtl/tunm_scan.sv =====
module tunm_scan
    import tunm_pkg::*;
#(
    parameter int MAX_NEEDLE = DEF_MAX_NEEDLE
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  scan_ctrl_t                           ctrl,
    input  logic [7:0]                           char_code,
    input  logic [MAX_NEEDLE-1:0]                eq,
    input  logic [$clog2(MAX_NEEDLE+1)-1:0]      needle_length,
    input  logic [5:0]                           scattered_min_length,
    input  logic [2:0]                           span_factor,
    output logic [2:0]                           tier
);

    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
    localparam int POS_W = $clog2(MAX_NEEDLE + 2);
    localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int LIM_W = LEN_W + 3;
    localparam int CMP_W = (LIM_W > 8) ? LIM_W : 8;
    localparam int LC_W  = (LEN_W > 6) ? LEN_W : 6;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(MAX_NEEDLE + 1);

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  prefix_alive_reg, prefix_alive_next;
    logic                  query_seen_reg, query_seen_next;
    logic                  prev_sep_reg, prev_sep_next;
    logic [MAX_NEEDLE-1:0] partial_reg, partial_next;
    logic [MAX_NEEDLE-1:0] sep_start_reg, sep_start_next;
    logic                  found_seg_reg, found_seg_next;
    logic                  found_sub_reg, found_sub_next;
    logic [7:0]            age_reg  [MAX_NEEDLE];
    logic [7:0]            age_next_arr [MAX_NEEDLE];
    logic [7:0]            best_span_reg, best_span_next;

    logic [LEN_W-1:0]      last_full;
    logic [IDX_W-1:0]      last_idx;
    logic                  len_nz;

    assign len_nz    = (needle_length != '0);
    assign last_full = needle_length - LEN_W'(1);
    assign last_idx  = last_full[IDX_W-1:0];

    always_comb begin
        logic                  start;
        logic                  pos_in;
        logic [MAX_NEEDLE-1:0] part_new;
        logic [MAX_NEEDLE-1:0] sep_new;
        logic [7:0]            a;
        logic [7:0]            b;
        logic [7:0]            last_age;
        logic [7:0]            span;

        pos_next          = pos_reg;
        prefix_alive_next = prefix_alive_reg;
        query_seen_next   = query_seen_reg;
        prev_sep_next     = prev_sep_reg;
        partial_next      = partial_reg;
        sep_start_next    = sep_start_reg;
        found_seg_next    = found_seg_reg;
        found_sub_next    = found_sub_reg;
        best_span_next    = best_span_reg;
        for (int k = 0; k < MAX_NEEDLE; k++) begin
            age_next_arr[k] = age_reg[k];
        end

        start    = (pos_reg != '0);
        pos_in   = (pos_reg < POS_W'(needle_length));
        part_new = ((partial_reg << 1) | MAX_NEEDLE'(start)) & eq;
        sep_new  = ((sep_start_reg << 1) | MAX_NEEDLE'(prev_sep_reg && start)) & eq;
        a        = '0;
        b        = '0;
        last_age = '0;
        span     = '0;

        if (ctrl.restart) begin
            pos_next          = '0;
            prefix_alive_next = 1'b1;
            query_seen_next   = 1'b0;
            prev_sep_next     = 1'b0;
            partial_next      = '0;
            sep_start_next    = '0;
            found_seg_next    = 1'b0;
            found_sub_next    = 1'b0;
            best_span_next    = AGE_NONE;
            for (int k = 0; k < MAX_NEEDLE; k++) begin
                age_next_arr[k] = AGE_NONE;
            end
        end else if (ctrl.step) begin
            // prefix tracking runs on the whole target, query text included
            if (prefix_alive_reg && pos_in && !eq[pos_reg[IDX_W-1:0]]) begin
                prefix_alive_next = 1'b0;
            end
            pos_next = (pos_reg == POS_CAP) ? pos_reg : pos_reg + POS_W'(1);

            if (!query_seen_reg) begin
                if (char_code == CH_QUERY || char_code == CH_HASH) begin
                    query_seen_next = 1'b1;
                end else begin
                    if (len_nz) begin
                        partial_next   = part_new;
                        sep_start_next = sep_new;
                        if (part_new[last_idx]) begin
                            found_sub_next = 1'b1;
                        end
                        if (sep_new[last_idx]) begin
                            found_seg_next = 1'b1;
                        end
                        // each prefix keeps the age of its youngest window start
                        for (int k = 0; k < MAX_NEEDLE; k++) begin
                            if (k < needle_length) begin
                                a = age_next(age_reg[k]);
                                if (k == 0) begin
                                    b = '0;
                                end else begin
                                    b = age_next(age_reg[(k == 0) ? 0 : k - 1]);
                                end
                                if (eq[k] && b < a) begin
                                    a = b;
                                end
                                age_next_arr[k] = a;
                            end
                        end
                        last_age = age_next_arr[last_idx];
                        span     = last_age + 8'd1;
                        if (eq[last_idx] && last_age != AGE_NONE && span < best_span_reg) begin
                            best_span_next = span;
                        end
                    end
                    prev_sep_next = is_sep(char_code);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg          <= '0;
            prefix_alive_reg <= 1'b1;
            query_seen_reg   <= 1'b0;
            prev_sep_reg     <= 1'b0;
            partial_reg      <= '0;
            sep_start_reg    <= '0;
            found_seg_reg    <= 1'b0;
            found_sub_reg    <= 1'b0;
            best_span_reg    <= AGE_NONE;
            for (int k = 0; k < MAX_NEEDLE; k++) begin
                age_reg[k] <= AGE_NONE;
            end
        end else begin
            pos_reg          <= pos_next;
            prefix_alive_reg <= prefix_alive_next;
            query_seen_reg   <= query_seen_next;
            prev_sep_reg     <= prev_sep_next;
            partial_reg      <= partial_next;
            sep_start_reg    <= sep_start_next;
            found_seg_reg    <= found_seg_next;
            found_sub_reg    <= found_sub_next;
            best_span_reg    <= best_span_next;
            for (int k = 0; k < MAX_NEEDLE; k++) begin
                age_reg[k] <= age_next_arr[k];
            end
        end
    end

    // Tier from the scan state as it stands
    always_comb begin
        logic [LIM_W-1:0] limit;
        limit = LIM_W'(span_factor) * LIM_W'(needle_length);
        if (!len_nz) begin
            tier = TIER_NONE;
        end else if (prefix_alive_reg && pos_reg >= POS_W'(needle_length)) begin
            tier = TIER_PREFIX;
        end else if (found_seg_reg) begin
            tier = TIER_SEGMENT;
        end else if (found_sub_reg) begin
            tier = TIER_SUBSTRING;
        end else if (LC_W'(needle_length) >= LC_W'(scattered_min_length)
                     && best_span_reg != AGE_NONE
                     && CMP_W'(best_span_reg) <= CMP_W'(limit)) begin
            tier = TIER_SCATTERED;
        end else begin
            tier = TIER_NONE;
        end
    end

endmodule

// ===== rtl/tiered_url_needle_matcher.sv =====
// Channel   Ports                               Carries
// --------  ----------------------------------  ---------------------------------------
// input     s_valid/s_ready, s_action,          needle clear/append, target byte,
//           s_char_code                         end of target
// result    m_valid/m_ready, m_tier,            one match tier per end of target
//           m_needle_overflow
// config    psel/penable/pwrite/paddr/pwdata,   scattered_min_length (0x0),
//           prdata, pready                      span_factor (0x4)
//
// One request per cycle sustained while no end-of-target request is stalled: a
// request is held in the input register; when it fires, all needle positions update in parallel.
// An end-of-target request passes the input register, then the result register, to m_*.
// Reset (aresetn low at a clock edge) empties the needle and restores the
// register defaults; there is no clearing pass.
// An end-of-target request waits in the input register while a tier is still
// unclaimed on m_*; other requests never stall on the result side.
module tiered_url_needle_matcher
    import tunm_pkg::*;
#(
    parameter int MAX_NEEDLE = DEF_MAX_NEEDLE
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_char_code,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_tier,
    output logic        m_needle_overflow
);

    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
    localparam int IDX_W = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

    // Configuration registers
    logic [5:0] scattered_min_length_reg;
    logic [2:0] span_factor_reg;

    // Input register
    logic       in_valid_reg;
    logic [1:0] in_action_reg;
    logic [7:0] in_char_reg;

    // Needle store: contents need no reset, only entries below the length are used
    logic [7:0]       needle_reg [MAX_NEEDLE];
    logic [LEN_W-1:0] needle_length_reg;
    logic             overflow_reg;

    // Result register
    logic       m_valid_reg;
    logic [2:0] m_tier_reg;
    logic       m_overflow_reg;

    logic                  fire;
    logic                  cfg_write;
    logic [MAX_NEEDLE-1:0] eq;
    logic [2:0]            tier;
    scan_ctrl_t            ctrl;

    // An end-of-target request needs a free result slot, anything else goes through
    assign fire    = in_valid_reg && (in_action_reg != ACT_END || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    assign ctrl.step    = fire && (in_action_reg == ACT_CHAR);
    assign ctrl.restart = fire && (in_action_reg != ACT_CHAR);

    // Compare the held byte against every needle position at once
    always_comb begin
        for (int k = 0; k < MAX_NEEDLE; k++) begin
            eq[k] = (k < needle_length_reg) && (needle_reg[k] == in_char_reg);
        end
    end

    // APB port: zero-wait, writes land on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_SCATTERED_MIN: prdata = 32'(scattered_min_length_reg);
            REG_SPAN_FACTOR:   prdata = 32'(span_factor_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scattered_min_length_reg <= SML_RESET;
            span_factor_reg          <= SPAN_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_SCATTERED_MIN: scattered_min_length_reg <= pwdata[5:0];
                REG_SPAN_FACTOR:   span_factor_reg          <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Input register: lowercase on the way in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_char_reg   <= to_lower(s_char_code);
        end
    end

    // Needle length and overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_length_reg <= '0;
            overflow_reg      <= 1'b0;
        end else if (fire && in_action_reg == ACT_CLEAR) begin
            needle_length_reg <= '0;
            overflow_reg      <= 1'b0;
        end else if (fire && in_action_reg == ACT_APPEND) begin
            if (needle_length_reg < LEN_W'(MAX_NEEDLE)) begin
                needle_length_reg <= needle_length_reg + LEN_W'(1);
            end else begin
                // drop the byte, flag it until the next clear
                overflow_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_action_reg == ACT_APPEND && needle_length_reg < LEN_W'(MAX_NEEDLE)) begin
            needle_reg[needle_length_reg[IDX_W-1:0]] <= in_char_reg;
        end
    end

    tunm_scan #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_scan (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .ctrl                 (ctrl),
        .char_code            (in_char_reg),
        .eq                   (eq),
        .needle_length        (needle_length_reg),
        .scattered_min_length (scattered_min_length_reg),
        .span_factor          (span_factor_reg),
        .tier                 (tier)
    );

    // Result register: load on end of target, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && in_action_reg == ACT_END) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_action_reg == ACT_END) begin
            m_tier_reg     <= tier;
            m_overflow_reg <= overflow_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_tier            = m_tier_reg;
    assign m_needle_overflow = m_overflow_reg;

endmodule

// ===== bench/tiered_url_needle_matcher_test.sv =====
`timescale 1ns / 1ps

module tiered_url_needle_matcher_test;
    import tunm_pkg::*;

    localparam int MAX_NDL        = DEF_MAX_NEEDLE;
    localparam int POS_SAT        = MAX_NDL + 1;
    // End of target passes the input and result registers; leave some margin.
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [7:0] LOWER_A = CH_UPPER_A + CASE_OFFSET;
    localparam logic [7:0] LOWER_Z = CH_UPPER_Z + CASE_OFFSET;

    typedef struct packed {
        logic [2:0] tier;
        logic       overflow;
    } match_rec_t;

    // How a random target relates to the loaded needle
    typedef enum int {
        SHAPE_PREFIX,
        SHAPE_SEGMENT,
        SHAPE_INNER,
        SHAPE_SPREAD,
        SHAPE_NOISE
    } url_shape_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action    = ACT_CLEAR;
    logic [7:0]  s_char_code = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [2:0]  m_tier;
    logic        m_needle_overflow;

    tiered_url_needle_matcher u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_char_code       (s_char_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tier            (m_tier),
        .m_needle_overflow (m_needle_overflow)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow copy of the matcher: needle, scan state and registers
    // ------------------------------------------------------------------
    logic [7:0]         ndl_byte [MAX_NDL];
    int unsigned        ndl_len;
    bit                 ndl_over;
    int unsigned        scan_pos;
    bit                 pfx_live;
    bit                 qry_hit;
    bit                 last_sep;
    bit                 seg_found;
    bit                 sub_found;
    logic [MAX_NDL-1:0] run_bits;
    logic [MAX_NDL-1:0] seg_bits;
    logic [7:0]         win_age [MAX_NDL];
    logic [7:0]         narrowest;
    int unsigned        cfg_min_len;
    int unsigned        cfg_span;

    match_rec_t  pending_matches[$];
    match_rec_t  head_rec;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned sent_count     = 0;
    int unsigned idle_cycles    = 0;
    int unsigned rx_hold        = 0;
    bit          send_gaps      = 1'b1;
    bit          recv_stalls    = 1'b1;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c | CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic bit is_delim(input logic [7:0] c);
        case (c)
            CH_SLASH, CH_DOT, CH_DASH, CH_UNDER, CH_PLUS, CH_COLON, CH_TILDE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Window ages stick at the "no window" value instead of wrapping.
    function automatic logic [7:0] age_step(input logic [7:0] a);
        if (a == AGE_NONE || a == AGE_NONE - 8'd1) begin
            return AGE_NONE;
        end
        return a + 8'd1;
    endfunction

    function automatic void restart_scan();
        scan_pos  = 0;
        pfx_live  = 1'b1;
        qry_hit   = 1'b0;
        last_sep  = 1'b0;
        run_bits  = '0;
        seg_bits  = '0;
        seg_found = 1'b0;
        sub_found = 1'b0;
        narrowest = AGE_NONE;
        for (int k = 0; k < MAX_NDL; k++) begin
            win_age[k] = AGE_NONE;
        end
    endfunction

    function automatic void reset_shadow();
        cfg_min_len = 32'(SML_RESET);
        cfg_span    = 32'(SPAN_RESET);
        ndl_len     = 0;
        ndl_over    = 1'b0;
        for (int k = 0; k < MAX_NDL; k++) begin
            ndl_byte[k] = '0;
        end
        restart_scan();
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        logic [MAX_NDL-1:0] eq;
        logic [7:0]         a;
        logic [7:0]         b;
        bit                 open;
        int unsigned        pos;
        int                 span;
        pos = scan_pos;
        eq  = '0;
        if (pfx_live && pos < ndl_len && ndl_byte[pos] != c) begin
            pfx_live = 1'b0;
        end
        scan_pos = (pos + 1 > POS_SAT) ? POS_SAT : pos + 1;
        // Everything from the first query or fragment mark on is ignored, but for prefix tracking
        if (qry_hit) begin
            return;
        end
        if (c == CH_QUERY || c == CH_HASH) begin
            qry_hit = 1'b1;
            return;
        end
        if (ndl_len > 0) begin
            for (int k = 0; k < int'(ndl_len); k++) begin
                eq[k] = (ndl_byte[k] == c);
            end
            // Occurrences only count from target index one on
            open = (pos >= 1);
            run_bits    = run_bits << 1;
            run_bits[0] = open;
            run_bits    = run_bits & eq;
            seg_bits    = seg_bits << 1;
            seg_bits[0] = open && last_sep;
            seg_bits    = seg_bits & eq;
            if (run_bits[ndl_len-1]) begin
                sub_found = 1'b1;
            end
            if (seg_bits[ndl_len-1]) begin
                seg_found = 1'b1;
            end
            // Walk down so each prefix sees the previous byte's ages
            for (int k = int'(ndl_len) - 1; k >= 0; k--) begin
                a = age_step(win_age[k]);
                if (ndl_byte[k] == c) begin
                    b = (k == 0) ? 8'd0 : age_step(win_age[k-1]);
                    if (b < a) begin
                        a = b;
                    end
                end
                win_age[k] = a;
            end
            if (ndl_byte[ndl_len-1] == c && win_age[ndl_len-1] != AGE_NONE) begin
                span = int'(win_age[ndl_len-1]) + 1;
                if (span < int'(narrowest)) begin
                    narrowest = span[7:0];
                end
            end
        end
        last_sep = is_delim(c);
    endfunction

    function automatic logic [2:0] tier_now();
        if (ndl_len == 0) begin
            return TIER_NONE;
        end
        if (pfx_live && scan_pos >= ndl_len) begin
            return TIER_PREFIX;
        end
        if (seg_found) begin
            return TIER_SEGMENT;
        end
        if (sub_found) begin
            return TIER_SUBSTRING;
        end
        if (ndl_len >= cfg_min_len && narrowest != AGE_NONE &&
            int'(narrowest) <= cfg_span * ndl_len) begin
            return TIER_SCATTERED;
        end
        return TIER_NONE;
    endfunction

    // Advance the shadow by one accepted request; report the tier it yields, if any.
    function automatic bit apply_request(input logic [1:0] act, input logic [7:0] code,
                                         output match_rec_t rec);
        logic [7:0] c;
        c   = fold_case(code);
        rec = '0;
        case (act)
            ACT_CLEAR: begin
                ndl_len  = 0;
                ndl_over = 1'b0;
                restart_scan();
            end
            ACT_APPEND: begin
                if (ndl_len < MAX_NDL) begin
                    ndl_byte[ndl_len] = c;
                    ndl_len++;
                end else begin
                    ndl_over = 1'b1;
                end
                restart_scan();
            end
            ACT_CHAR: begin
                scan_byte(c);
            end
            default: begin
                rec.tier     = tier_now();
                rec.overflow = ndl_over;
                restart_scan();
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Mostly back to back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 30);
    endfunction

    function automatic logic [7:0] pick_sep();
        case ($urandom_range(0, 6))
            0: return CH_SLASH;
            1: return CH_DOT;
            2: return CH_DASH;
            3: return CH_UNDER;
            4: return CH_PLUS;
            5: return CH_COLON;
            default: return CH_TILDE;
        endcase
    endfunction

    // Small alphabet so that needles actually turn up in targets
    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return LOWER_A + 8'($urandom_range(0, 3));
        end else if (r < 80) begin
            return pick_sep();
        end else if (r < 84) begin
            return $urandom_range(0, 1) ? CH_QUERY : CH_HASH;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] vary_case(input logic [7:0] c);
        if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(0, 2) == 0) begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Request driver, result checker, receiver stalls, watchdog
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s on result %0d: got %0d, expected %0d",
                 $realtime, field, results_seen, got, want);
        mismatch_count++;
    endtask

    // Present one request and hold it until the matcher takes it.
    task automatic send_request(input logic [1:0] act, input logic [7:0] code);
        int         gap;
        match_rec_t rec;
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_char_code <= code;
        do @(posedge aclk); while (!s_ready);
        if (apply_request(act, code, rec)) begin
            pending_matches.push_back(rec);
        end
        sent_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_matches.size() == 0) begin
                report_mismatch("tier with nothing pending", 32'(m_tier), 32'(TIER_NONE));
            end else begin
                head_rec = pending_matches.pop_front();
                if (m_tier !== head_rec.tier) begin
                    report_mismatch("tier", 32'(m_tier), 32'(head_rec.tier));
                end
                if (m_needle_overflow !== head_rec.overflow) begin
                    report_mismatch("needle_overflow", 32'(m_needle_overflow),
                                    32'(head_rec.overflow));
                end
            end
        end
    end

    // Drop m_ready for random stretches while stalls are enabled
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            if (recv_stalls && $urandom_range(0, 3) == 0) begin
                rx_hold <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drop valid, drain every pending tier, then let the pipeline settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write a register, then read it back.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        logic [31:0] mask;
        mask    = (idx == REG_SCATTERED_MIN) ? 32'h3F : 32'h7;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_SCATTERED_MIN) begin
            cfg_min_len = 32'(value[5:0]);
        end else begin
            cfg_span = 32'(value[2:0]);
        end
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if ((prdata & mask) !== (value & mask)) begin
            report_mismatch("register readback", prdata & mask, value & mask);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input int unsigned min_len, input int unsigned span);
        wait_idle();
        write_reg(REG_SCATTERED_MIN, min_len);
        write_reg(REG_SPAN_FACTOR, span);
    endtask

    task automatic load_word(input string s);
        send_request(ACT_CLEAR, 8'($urandom_range(0, 255)));
        for (int i = 0; i < s.len(); i++) begin
            send_request(ACT_APPEND, s[i]);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_request(ACT_CHAR, s[i]);
        end
    endtask

    task automatic end_target();
        send_request(ACT_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic load_needle(input int unsigned n);
        send_request(ACT_CLEAR, 8'($urandom_range(0, 255)));
        repeat (n) send_request(ACT_APPEND, vary_case(rand_byte()));
    endtask

    // Build a target around the current needle, stream it and close it.
    task automatic send_target(input url_shape_t shape);
        logic [7:0] text[$];
        int         cut;
        int         i;
        text = {};
        if (shape != SHAPE_PREFIX) begin
            repeat ($urandom_range(shape == SHAPE_NOISE ? 0 : 1, 5)) begin
                text.push_back(rand_byte());
            end
        end
        if (shape == SHAPE_SEGMENT) begin
            text.push_back(pick_sep());
        end
        if (shape != SHAPE_NOISE) begin
            for (i = 0; i < int'(ndl_len); i++) begin
                if (shape == SHAPE_SPREAD && i > 0) begin
                    repeat ($urandom_range(0, 2)) text.push_back(rand_byte());
                end
                text.push_back(ndl_byte[i]);
            end
        end
        repeat ($urandom_range(0, 4)) text.push_back(rand_byte());
        // Now and then cut the loose tiers short with a query or fragment mark
        cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, text.size()) : -1;
        for (i = 0; i <= text.size(); i++) begin
            if (i == cut) begin
                send_request(ACT_CHAR, $urandom_range(0, 1) ? CH_QUERY : CH_HASH);
            end
            if (i < text.size()) begin
                send_request(ACT_CHAR, vary_case(text[i]));
            end
        end
        // Occasionally change the needle in the middle of a target
        if ($urandom_range(0, 19) == 0) begin
            send_request($urandom_range(0, 3) == 0 ? ACT_CLEAR : ACT_APPEND, rand_byte());
        end
        end_target();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_power_on_defaults();
        // Empty needle after reset, then extreme byte values as needle and target
        send_request(ACT_END, 8'hFF);
        send_request(ACT_APPEND, 8'hFF);
        send_request(ACT_APPEND, 8'h00);
        send_request(ACT_CHAR, 8'hFF);
        send_request(ACT_CHAR, 8'h00);
        send_request(ACT_END, 8'h00);
    endtask

    task automatic test_match_tiers();
        load_word("Ab");
        send_text("aB/x");
        end_target();
        send_text("x.AB");
        end_target();
        send_text("xab");
        end_target();
        send_text("x#ab");
        end_target();
        load_word("abc");
        send_text("aXbYc");
        end_target();
    endtask

    task automatic test_needle_restart();
        load_word("ab");
        send_text("zab");
        send_request(ACT_APPEND, "c");
        send_text("abc");
        end_target();
        send_text("xabc");
        send_request(ACT_CLEAR, 8'hFF);
        end_target();
    endtask

    task automatic test_needle_overflow();
        load_needle(MAX_NDL + 2);
        send_target(SHAPE_INNER);
        send_target(SHAPE_SPREAD);
        send_request(ACT_CLEAR, 8'h00);
        end_target();
    endtask

    // A window far wider than 255 bytes must not qualify once ages saturate.
    task automatic test_wide_window();
        set_config(2, 4);
        send_gaps = 1'b0;
        load_word("az");
        send_text("a");
        repeat (260) send_request(ACT_CHAR, "q");
        send_text("z");
        end_target();
        send_gaps = 1'b1;
    endtask

    task automatic test_random_urls(input int unsigned min_len, input int unsigned span,
                                    input int unsigned budget);
        int unsigned stop_at;
        int          r;
        set_config(min_len, span);
        stop_at = sent_count + budget;
        while (sent_count < stop_at) begin
            send_gaps   = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 88) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    load_needle($urandom_range(1, 4));
                end else if (r < 90) begin
                    load_needle($urandom_range(5, 10));
                end else if (r < 97) begin
                    load_needle($urandom_range(11, MAX_NDL));
                end else begin
                    load_needle($urandom_range(MAX_NDL + 1, MAX_NDL + 4));
                end
                repeat ($urandom_range(1, 4)) send_target(url_shape_t'($urandom_range(0, 4)));
            end else begin
                // Raw noise on every field
                repeat ($urandom_range(1, 8)) begin
                    send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        reset_shadow();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_power_on_defaults();
        test_match_tiers();
        test_needle_restart();
        test_needle_overflow();
        test_wide_window();
        test_random_urls(0, 1, 10);
        test_random_urls(MAX_NDL, 4, 10);
        test_random_urls(1, 4, 10);
        test_random_urls(32'(SML_RESET), 32'(SPAN_RESET), 10);
        test_random_urls($urandom_range(0, MAX_NDL), $urandom_range(1, 4), 10);
        wait_idle();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tunm_pkg.sv
rtl/tunm_scan.sv
rtl/tiered_url_needle_matcher.sv
bench/tiered_url_needle_matcher_test.sv
